/* hdl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the Banker's safety check unit: request and
// register codes, controller states and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_MAX_RESOURCES = 8;
  localparam int DEF_VALUE_BITS    = 8;

  localparam int CFG_DATA_BITS = 5;

  localparam logic [1:0] REQ_LOAD_PROC  = 2'd0;
  localparam logic [1:0] REQ_LOAD_AVAIL = 2'd1;
  localparam logic [1:0] REQ_CHECK      = 2'd2;

  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_SEL,
    ST_RD,
    ST_CMP,
    ST_ARD,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_proc;
    logic load_avail;
    logic copy;
    logic clear_marks;
    logic read;
    logic add;
    logic mark;
  } dp_cmd_t;

  typedef struct packed {
    logic fits;
    logic done;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/bsc_datapath.sv */
// ----------------------------------------------------------------------------
// bsc_datapath
// Storage and arithmetic of the safety check: the allocation and need
// memory, the loaded and working available vectors, the finished marks and
// the need-against-available compare.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_datapath #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
  parameter int VALUE_BITS    = bsc_pkg::DEF_VALUE_BITS
) (
  input  wire                                    clk,
  input  wire  bsc_pkg::dp_cmd_t                 cmd,
  input  wire  [$clog2(MAX_PROCESSES+1)-1:0]     proc_idx,
  input  wire  [$clog2(MAX_RESOURCES+1)-1:0]     res_idx,
  input  wire  [3:0]                             in_process_index,
  input  wire  [2:0]                             in_resource_index,
  input  wire  [7:0]                             in_alloc_value,
  input  wire  [7:0]                             in_max_value,
  input  wire  [7:0]                             in_avail_value,
  output bsc_pkg::dp_status_t                    status
);

  localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NW  = VALUE_BITS + 1;
  localparam int WW  = VALUE_BITS + NW;
  localparam int AW  = VALUE_BITS + $clog2(MAX_PROCESSES + 1);
  localparam int PIW = (PW > 4) ? PW : 4;
  localparam int RIW = (RW > 3) ? RW : 3;
  localparam int VW  = (VALUE_BITS > 8) ? VALUE_BITS : 8;

  logic [WW-1:0]         mem [2**(PW+RW)];
  logic [WW-1:0]         rd_data_r;
  logic [VALUE_BITS-1:0] avail_loaded_r [2**RW];
  logic [AW-1:0]         avail_work_r   [2**RW];
  logic [2**PW-1:0]      marks_r;

  logic [PIW-1:0]        pi_ext;
  logic [RIW-1:0]        ri_ext;
  logic [VW-1:0]         alloc_ext;
  logic [VW-1:0]         max_ext;
  logic [VW-1:0]         avail_ext;
  logic [VALUE_BITS-1:0] alloc_v;
  logic [VALUE_BITS-1:0] max_v;
  logic [NW-1:0]         need_v;
  logic                  load_in_range;
  logic [PW+RW-1:0]      wr_addr;
  logic [PW+RW-1:0]      rd_addr;
  logic [RW-1:0]         j_addr;
  logic [PW-1:0]         i_addr;
  logic [VALUE_BITS-1:0] rd_alloc;
  logic [NW-1:0]         rd_need;

  assign pi_ext    = PIW'(in_process_index);
  assign ri_ext    = RIW'(in_resource_index);
  assign alloc_ext = VW'(in_alloc_value);
  assign max_ext   = VW'(in_max_value);
  assign avail_ext = VW'(in_avail_value);
  assign alloc_v   = alloc_ext[VALUE_BITS-1:0];
  assign max_v     = max_ext[VALUE_BITS-1:0];
  assign need_v    = {1'b0, max_v} - {1'b0, alloc_v};

  assign load_in_range = (32'(in_process_index) < 32'(MAX_PROCESSES)) &&
                         (32'(in_resource_index) < 32'(MAX_RESOURCES));

  assign wr_addr = {pi_ext[PW-1:0], ri_ext[RW-1:0]};
  assign i_addr  = proc_idx[PW-1:0];
  assign j_addr  = res_idx[RW-1:0];
  assign rd_addr = {i_addr, j_addr};

  assign rd_alloc = rd_data_r[WW-1:NW];
  assign rd_need  = rd_data_r[NW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_proc && load_in_range) begin
      mem[wr_addr] <= {alloc_v, need_v};
    end
    if (cmd.read) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_avail && (32'(in_resource_index) < 32'(MAX_RESOURCES))) begin
      avail_loaded_r[ri_ext[RW-1:0]] <= avail_ext[VALUE_BITS-1:0];
    end
    if (cmd.copy) begin
      avail_work_r[j_addr] <= AW'(avail_loaded_r[j_addr]);
    end else if (cmd.add) begin
      avail_work_r[j_addr] <= avail_work_r[j_addr] + AW'(rd_alloc);
    end
    if (cmd.clear_marks) begin
      marks_r <= '0;
    end else if (cmd.mark) begin
      marks_r[i_addr] <= 1'b1;
    end
  end

  // A negative need never blocks; otherwise it must not exceed the working amount.
  assign status.fits = rd_need[NW-1] ||
                       (AW'(rd_need[VALUE_BITS-1:0]) <= avail_work_r[j_addr]);
  assign status.done = marks_r[i_addr];

endmodule

`default_nettype wire

/* hdl/bsc_controller.sv */
// ----------------------------------------------------------------------------
// bsc_controller
// Sequencer of the safety check: configuration registers, request decode,
// process and resource counters, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_controller #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_wr_en,
  input  wire                                    cfg_index,
  input  wire  [bsc_pkg::CFG_DATA_BITS-1:0]      cfg_wr_data,
  input  wire                                    start,
  output logic                                   busy,
  input  wire  [1:0]                             in_req_type,
  output logic                                   out_valid,
  output logic [3:0]                             out_process_id,
  output logic                                   out_process_valid,
  output logic                                   out_safe,
  output logic                                   out_last,
  output bsc_pkg::dp_cmd_t                       cmd,
  output logic [$clog2(MAX_PROCESSES+1)-1:0]     proc_idx,
  output logic [$clog2(MAX_RESOURCES+1)-1:0]     res_idx,
  input  wire  bsc_pkg::dp_status_t              status
);

  localparam int CW  = $clog2(MAX_PROCESSES + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);
  localparam int PXW = (CW > 4) ? CW : 4;

  bsc_pkg::state_t state_r, state_nxt;
  logic [4:0]     pc_r, pc_nxt;
  logic [3:0]     rc_r, rc_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [RCW-1:0] m_r, m_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [RCW-1:0] j_r, j_nxt;
  logic [CW-1:0]  total_r, total_nxt;
  logic           pf_r, pf_nxt;
  logic           ov_r, ov_nxt;
  logic [3:0]     opid_r, opid_nxt;
  logic           opv_r, opv_nxt;
  logic           osafe_r, osafe_nxt;
  logic           olast_r, olast_nxt;

  logic [CW-1:0]  n_sat;
  logic [RCW-1:0] m_sat;
  logic [PXW-1:0] pid_ext;
  logic           last_fin;
  logic           last_res;

  assign n_sat = (32'(pc_r) > 32'(MAX_PROCESSES)) ? CW'(MAX_PROCESSES) : CW'(pc_r);
  assign m_sat = (32'(rc_r) > 32'(MAX_RESOURCES)) ? RCW'(MAX_RESOURCES) : RCW'(rc_r);
  assign pid_ext  = PXW'(i_r);
  assign last_fin = ((total_r + CW'(1)) == n_r);
  assign last_res = ((j_r + RCW'(1)) == m_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsc_pkg::ST_IDLE;
      pc_r    <= 5'd1;
      rc_r    <= 4'd1;
      total_r <= '0;
      pf_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      rc_r    <= rc_nxt;
      total_r <= total_nxt;
      pf_r    <= pf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    opid_r  <= opid_nxt;
    opv_r   <= opv_nxt;
    osafe_r <= osafe_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    pc_nxt = pc_r;
    rc_nxt = rc_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        bsc_pkg::REG_PROCESS_COUNT:  pc_nxt = cfg_wr_data;
        bsc_pkg::REG_RESOURCE_COUNT: rc_nxt = cfg_wr_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    total_nxt = total_r;
    pf_nxt    = pf_r;
    ov_nxt    = 1'b0;
    opid_nxt  = opid_r;
    opv_nxt   = opv_r;
    osafe_nxt = osafe_r;
    olast_nxt = olast_r;
    cmd       = '0;
    case (state_r)
      bsc_pkg::ST_IDLE: begin
        if (start) begin
          case (in_req_type)
            bsc_pkg::REQ_LOAD_PROC:  cmd.load_proc = 1'b1;
            bsc_pkg::REQ_LOAD_AVAIL: cmd.load_avail = 1'b1;
            bsc_pkg::REQ_CHECK: begin
              n_nxt           = n_sat;
              m_nxt           = m_sat;
              j_nxt           = '0;
              total_nxt       = '0;
              cmd.clear_marks = 1'b1;
              if (n_sat == '0) begin
                ov_nxt    = 1'b1;
                opid_nxt  = 4'd0;
                opv_nxt   = 1'b0;
                osafe_nxt = 1'b1;
                olast_nxt = 1'b1;
              end else begin
                state_nxt = bsc_pkg::ST_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      bsc_pkg::ST_COPY: begin
        if (j_r == m_r) begin
          i_nxt     = '0;
          pf_nxt    = 1'b0;
          state_nxt = bsc_pkg::ST_SEL;
        end else begin
          cmd.copy = 1'b1;
          j_nxt    = j_r + RCW'(1);
        end
      end
      bsc_pkg::ST_SEL: begin
        if (i_r == n_r) begin
          if (!pf_r) begin
            ov_nxt    = 1'b1;
            opid_nxt  = 4'd0;
            opv_nxt   = 1'b0;
            osafe_nxt = 1'b0;
            olast_nxt = 1'b1;
            state_nxt = bsc_pkg::ST_IDLE;
          end else begin
            i_nxt  = '0;
            pf_nxt = 1'b0;
          end
        end else if (status.done) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt     = '0;
          state_nxt = (m_r == '0) ? bsc_pkg::ST_FIN : bsc_pkg::ST_RD;
        end
      end
      bsc_pkg::ST_RD: begin
        cmd.read  = 1'b1;
        state_nxt = bsc_pkg::ST_CMP;
      end
      bsc_pkg::ST_CMP: begin
        if (!status.fits) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = bsc_pkg::ST_SEL;
        end else if (last_res) begin
          j_nxt     = '0;
          state_nxt = bsc_pkg::ST_ARD;
        end else begin
          j_nxt     = j_r + RCW'(1);
          state_nxt = bsc_pkg::ST_RD;
        end
      end
      bsc_pkg::ST_ARD: begin
        cmd.read  = 1'b1;
        state_nxt = bsc_pkg::ST_ACC;
      end
      bsc_pkg::ST_ACC: begin
        cmd.add = 1'b1;
        if (last_res) begin
          state_nxt = bsc_pkg::ST_FIN;
        end else begin
          j_nxt     = j_r + RCW'(1);
          state_nxt = bsc_pkg::ST_ARD;
        end
      end
      bsc_pkg::ST_FIN: begin
        cmd.mark  = 1'b1;
        total_nxt = total_r + CW'(1);
        pf_nxt    = 1'b1;
        ov_nxt    = 1'b1;
        opid_nxt  = pid_ext[3:0];
        opv_nxt   = 1'b1;
        osafe_nxt = last_fin;
        olast_nxt = last_fin;
        if (last_fin) begin
          state_nxt = bsc_pkg::ST_IDLE;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = bsc_pkg::ST_SEL;
        end
      end
      default: state_nxt = bsc_pkg::ST_IDLE;
    endcase
  end

  assign busy              = (state_r != bsc_pkg::ST_IDLE);
  assign out_valid         = ov_r;
  assign out_process_id    = opid_r;
  assign out_process_valid = opv_r;
  assign out_safe          = osafe_r;
  assign out_last          = olast_r;
  assign proc_idx          = i_r;
  assign res_idx           = j_r;

endmodule

`default_nettype wire

/* hdl/bankers_safety_check_unit.sv */
// ----------------------------------------------------------------------------
// bankers_safety_check_unit
// Banker's algorithm safety check over loaded allocation, maximum and
// available tables.
//
// A request transfer happens at a clock edge with start high and busy low.
// Load requests (process entry, available entry) leave busy low, so loads
// stream at one per cycle; unknown request codes are dropped. A check with
// zero processes gives its single result in the next cycle without raising
// busy; any other check raises busy until its final result. It first
// copies the available vector, then walks the processes in index order,
// pass after pass. For each unfinished process it reads and compares the
// need of each resource against the working amount until a shortfall; if
// none, it reads each allocation, adds it back and finishes the process.
// Each visit and each pass end also go through a selection step. Reads use
// the single read port of the allocation and need memory.
// Each result is a transfer of one cycle marked by out_valid; the receiver
// cannot stall, so results never wait. A safe check ends with the last
// finished process marked last and safe; an unsafe one with an extra result
// naming no process. Reset sets both counts to one and returns to idle;
// the loaded tables keep no reset value and must be written before use.
// Configuration writes take effect at once; the user must make them while
// idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_safety_check_unit #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
  parameter int VALUE_BITS    = bsc_pkg::DEF_VALUE_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire                                 cfg_index,
  input  wire  [bsc_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [1:0]                          in_req_type,
  input  wire  [3:0]                          in_process_index,
  input  wire  [2:0]                          in_resource_index,
  input  wire  [7:0]                          in_alloc_value,
  input  wire  [7:0]                          in_max_value,
  input  wire  [7:0]                          in_avail_value,
  output logic                                out_valid,
  output logic [3:0]                          out_process_id,
  output logic                                out_process_valid,
  output logic                                out_safe,
  output logic                                out_last
);

  bsc_pkg::dp_cmd_t                     cmd;
  bsc_pkg::dp_status_t                  status;
  logic [$clog2(MAX_PROCESSES+1)-1:0]   proc_idx;
  logic [$clog2(MAX_RESOURCES+1)-1:0]   res_idx;

  bsc_controller #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .out_valid         (out_valid),
    .out_process_id    (out_process_id),
    .out_process_valid (out_process_valid),
    .out_safe          (out_safe),
    .out_last          (out_last),
    .cmd               (cmd),
    .proc_idx          (proc_idx),
    .res_idx           (res_idx),
    .status            (status)
  );

  bsc_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .proc_idx          (proc_idx),
    .res_idx           (res_idx),
    .in_process_index  (in_process_index),
    .in_resource_index (in_resource_index),
    .in_alloc_value    (in_alloc_value),
    .in_max_value      (in_max_value),
    .in_avail_value    (in_avail_value),
    .status            (status)
  );

endmodule

`default_nettype wire

/* tb/sv/bankers_safe_sequence_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safe_sequence_checker
// Watches the configuration port and both transfer channels of the safety
// check unit, keeps its own copy of the loaded tables and counts, works out
// the safe sequence that each check request must produce and compares every
// result transfer against the oldest expected entry.
// ----------------------------------------------------------------------------

module bankers_safe_sequence_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire                                cfg_index,
  input  wire [bsc_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
  input  wire                                start,
  input  wire                                busy,
  input  wire [1:0]                          in_req_type,
  input  wire [3:0]                          in_process_index,
  input  wire [2:0]                          in_resource_index,
  input  wire [7:0]                          in_alloc_value,
  input  wire [7:0]                          in_max_value,
  input  wire [7:0]                          in_avail_value,
  input  wire                                out_valid,
  input  wire [3:0]                          out_process_id,
  input  wire                                out_process_valid,
  input  wire                                out_safe,
  input  wire                                out_last,
  output int                                 mismatches,
  output int                                 pending
);

  localparam int MAX_P = bsc_pkg::DEF_MAX_PROCESSES;
  localparam int MAX_R = bsc_pkg::DEF_MAX_RESOURCES;

  typedef struct packed {
    logic [3:0] process_id;
    logic       process_valid;
    logic       safe;
    logic       last;
  } seq_entry_t;

  logic [7:0]        alloc_tbl [MAX_P][MAX_R];
  logic signed [8:0] need_tbl  [MAX_P][MAX_R];
  logic [7:0]        avail_tbl [MAX_R];
  logic [4:0]        proc_count_r;
  logic [3:0]        res_count_r;
  seq_entry_t        expected_seq_q [$];

  task automatic push_entry(input int pid, input bit pvalid, input bit safe_bit,
                            input bit last_bit);
    seq_entry_t e;
    e.process_id    = pid[3:0];
    e.process_valid = pvalid;
    e.safe          = safe_bit;
    e.last          = last_bit;
    expected_seq_q.push_back(e);
  endtask

  task automatic predict_safe_sequence();
    int         np;
    int         mp;
    int         done_cnt;
    int         need_v;
    int         avail_v;
    bit         found;
    bit         fits;
    bit         finished [MAX_P];
    logic [12:0] work [MAX_R];
    np = (proc_count_r > MAX_P) ? MAX_P : proc_count_r;
    mp = (res_count_r > MAX_R) ? MAX_R : res_count_r;
    for (int j = 0; j < MAX_R; j++) work[j] = {5'd0, avail_tbl[j]};
    for (int i = 0; i < MAX_P; i++) finished[i] = 1'b0;
    done_cnt = 0;
    if (np == 0) begin
      push_entry(0, 1'b0, 1'b1, 1'b1);
      return;
    end
    while (done_cnt < np) begin
      found = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!finished[i]) begin
          fits = 1'b1;
          for (int j = 0; j < mp; j++) begin
            need_v  = need_tbl[i][j];
            avail_v = work[j];
            if (fits && need_v > avail_v) fits = 1'b0;
          end
          if (fits) begin
            for (int j = 0; j < mp; j++) work[j] = work[j] + alloc_tbl[i][j];
            finished[i] = 1'b1;
            done_cnt++;
            found = 1'b1;
            if (done_cnt == np) push_entry(i, 1'b1, 1'b1, 1'b1);
            else push_entry(i, 1'b1, 1'b0, 1'b0);
          end
        end
      end
      if (!found) begin
        push_entry(0, 1'b0, 1'b0, 1'b1);
        return;
      end
    end
  endtask

  always @(posedge clk) begin
    seq_entry_t exp_e;
    if (!rst_n) begin
      proc_count_r = 5'd1;
      res_count_r  = 4'd1;
      mismatches   = 0;
      expected_seq_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_seq_q.size() == 0) begin
          $error("unexpected result: process_id %0d process_valid %0d safe %0d last %0d",
                 out_process_id, out_process_valid, out_safe, out_last);
          mismatches++;
        end else begin
          exp_e = expected_seq_q.pop_front();
          if (out_process_id !== exp_e.process_id) begin
            $error("process_id: expected %0d, actual %0d", exp_e.process_id,
                   out_process_id);
            mismatches++;
          end
          if (out_process_valid !== exp_e.process_valid) begin
            $error("process_valid: expected %0d, actual %0d", exp_e.process_valid,
                   out_process_valid);
            mismatches++;
          end
          if (out_safe !== exp_e.safe) begin
            $error("safe: expected %0d, actual %0d", exp_e.safe, out_safe);
            mismatches++;
          end
          if (out_last !== exp_e.last) begin
            $error("last: expected %0d, actual %0d", exp_e.last, out_last);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == bsc_pkg::REG_PROCESS_COUNT) proc_count_r = cfg_wr_data[4:0];
        else res_count_r = cfg_wr_data[3:0];
      end
      if (start && !busy) begin
        case (in_req_type)
          bsc_pkg::REQ_LOAD_PROC: begin
            alloc_tbl[in_process_index][in_resource_index] = in_alloc_value;
            need_tbl[in_process_index][in_resource_index] =
              {1'b0, in_max_value} - {1'b0, in_alloc_value};
          end
          bsc_pkg::REQ_LOAD_AVAIL: begin
            avail_tbl[in_resource_index] = in_avail_value;
          end
          bsc_pkg::REQ_CHECK: begin
            predict_safe_sequence();
          end
          default: begin
          end
        endcase
      end
    end
    pending = expected_seq_q.size();
  end

endmodule

/* tb/sv/bankers_safety_check_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safety_check_unit_tb
// Drives the safety check unit with a short directed sequence and then with
// random phases of configuration writes, table loads and check requests,
// with random gaps between transfers, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module bankers_safety_check_unit_tb;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 300;
  localparam int MAX_P        = bsc_pkg::DEF_MAX_PROCESSES;
  localparam int MAX_R        = bsc_pkg::DEF_MAX_RESOURCES;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic                              cfg_index = bsc_pkg::REG_PROCESS_COUNT;
  logic [bsc_pkg::CFG_DATA_BITS-1:0] cfg_wr_data = '0;
  logic                              start = 1'b0;
  logic [1:0]                        in_req_type = bsc_pkg::REQ_LOAD_PROC;
  logic [3:0]                        in_process_index = '0;
  logic [2:0]                        in_resource_index = '0;
  logic [7:0]                        in_alloc_value = '0;
  logic [7:0]                        in_max_value = '0;
  logic [7:0]                        in_avail_value = '0;
  wire                               busy;
  wire                               out_valid;
  wire  [3:0]                        out_process_id;
  wire                               out_process_valid;
  wire                               out_safe;
  wire                               out_last;
  int                                mismatches;
  int                                pending;
  int                                idle_cycles = 0;
  int                                item_count = 0;
  bit                                burst = 1'b1;
  bit                                proc_written [MAX_P][MAX_R];
  bit                                avail_written [MAX_R];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bankers_safety_check_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_process_index (in_process_index),
    .in_resource_index(in_resource_index),
    .in_alloc_value   (in_alloc_value),
    .in_max_value     (in_max_value),
    .in_avail_value   (in_avail_value),
    .out_valid        (out_valid),
    .out_process_id   (out_process_id),
    .out_process_valid(out_process_valid),
    .out_safe         (out_safe),
    .out_last         (out_last)
  );

  bankers_safe_sequence_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_process_index (in_process_index),
    .in_resource_index(in_resource_index),
    .in_alloc_value   (in_alloc_value),
    .in_max_value     (in_max_value),
    .in_avail_value   (in_avail_value),
    .out_valid        (out_valid),
    .out_process_id   (out_process_id),
    .out_process_valid(out_process_valid),
    .out_safe         (out_safe),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] req, input int pi, input int ri,
                           input int alloc_v, input int max_v, input int avail_v);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start             <= 1'b1;
    in_req_type       <= req;
    in_process_index  <= pi[3:0];
    in_resource_index <= ri[2:0];
    in_alloc_value    <= alloc_v[7:0];
    in_max_value      <= max_v[7:0];
    in_avail_value    <= avail_v[7:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req != REQ_UNKNOWN) item_count++;
  endtask

  task automatic load_proc(input int pi, input int ri, input int alloc_v, input int max_v);
    send_item(bsc_pkg::REQ_LOAD_PROC, pi, ri, alloc_v, max_v, $urandom_range(0, 255));
    proc_written[pi][ri] = 1'b1;
  endtask

  task automatic load_avail(input int ri, input int avail_v);
    send_item(bsc_pkg::REQ_LOAD_AVAIL, $urandom_range(0, 15), ri, $urandom_range(0, 255),
              $urandom_range(0, 255), avail_v);
    avail_written[ri] = 1'b1;
  endtask

  task automatic run_check();
    send_item(bsc_pkg::REQ_CHECK, $urandom_range(0, 15), $urandom_range(0, 7),
              $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_counts(input int pc, input int rc);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= bsc_pkg::REG_PROCESS_COUNT;
    cfg_wr_data <= pc[4:0];
    @(negedge clk);
    cfg_index   <= bsc_pkg::REG_RESOURCE_COUNT;
    cfg_wr_data <= {1'b0, rc[3:0]};
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic load_random_proc(input int pi, input int ri, input int mode);
    int a;
    case (mode)
      0: load_proc(pi, ri, $urandom_range(0, 255), $urandom_range(0, 255));
      1: begin
        a = $urandom_range(0, 20);
        load_proc(pi, ri, a, a + $urandom_range(0, 15));
      end
      default: begin
        a = $urandom_range(0, 40);
        load_proc(pi, ri, a, $urandom_range(0, a + 8));
      end
    endcase
  endtask

  task automatic load_random_avail(input int ri, input int mode);
    if (mode == 0) load_avail(ri, $urandom_range(0, 255));
    else load_avail(ri, $urandom_range(0, 15));
  endtask

  task automatic fill_missing(input int np, input int mp, input int mode);
    for (int i = 0; i < np; i++)
      for (int j = 0; j < mp; j++)
        if (!proc_written[i][j]) load_random_proc(i, j, mode);
    for (int j = 0; j < mp; j++)
      if (!avail_written[j]) load_random_avail(j, mode);
  endtask

  initial begin
    int pc;
    int rc;
    int np;
    int mp;
    int mode;
    int r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_counts(1, 1);
    load_proc(0, 0, 0, 0);
    load_avail(0, 0);
    run_check();
    send_item(REQ_UNKNOWN, 5, 3, 170, 85, 60);
    load_proc(15, 7, 255, 0);
    load_avail(7, 255);
    load_proc(1, 0, 0, 255);
    wait_idle();
    set_counts(0, 1);
    run_check();
    wait_idle();
    set_counts(2, 0);
    run_check();
    wait_idle();
    set_counts(2, 1);
    load_proc(0, 0, 0, 255);
    load_proc(1, 0, 255, 255);
    load_avail(0, 0);
    run_check();
    load_proc(0, 0, 255, 0);
    load_proc(1, 0, 0, 255);
    load_avail(0, 0);
    run_check();
    load_proc(0, 0, 0, 255);
    load_proc(1, 0, 0, 200);
    load_avail(0, 10);
    run_check();

    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      r = $urandom_range(0, 15);
      pc = (r == 0) ? 0 : (r == 1) ? 16 : (r == 2) ? $urandom_range(17, 31)
                                                     : $urandom_range(1, 6);
      r = $urandom_range(0, 15);
      rc = (r == 0) ? 0 : (r == 1) ? 8 : (r == 2) ? $urandom_range(9, 15)
                                                    : $urandom_range(1, 3);
      np = (pc > MAX_P) ? MAX_P : pc;
      mp = (rc > MAX_R) ? MAX_R : rc;
      r = $urandom_range(0, 3);
      mode = (r == 0) ? 0 : (r == 1) ? 2 : 1;
      wait_idle();
      burst = ($urandom_range(0, 3) == 0);
      set_counts(pc, rc);
      repeat ($urandom_range(1, 3)) begin
        fill_missing(np, mp, mode);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0 || np == 0 || mp == 0)
            load_random_proc($urandom_range(0, 15), $urandom_range(0, 7), mode);
          else
            load_random_proc($urandom_range(0, np - 1), $urandom_range(0, mp - 1), mode);
        end
        repeat ($urandom_range(0, 2)) load_random_avail($urandom_range(0, 7), mode);
        if ($urandom_range(0, 3) == 0)
          send_item(REQ_UNKNOWN, $urandom_range(0, 15), $urandom_range(0, 7),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        run_check();
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
